### src/abp_pkg.sv
package abp_pkg;

  // Action codes carried on in_tuser
  localparam logic [2:0] ACT_RAW     = 3'd0;
  localparam logic [2:0] ACT_RICE    = 3'd1;
  localparam logic [2:0] ACT_UTF8    = 3'd2;
  localparam logic [2:0] ACT_ALIGN   = 3'd3;
  localparam logic [2:0] ACT_CLEAR   = 3'd4;
  localparam logic [2:0] ACT_RESTART = 3'd5;

  localparam logic [7:0]  CRC8_POLY  = 8'h07;
  localparam logic [15:0] CRC16_POLY = 16'h8005;

  // Controller to datapath
  typedef struct packed {
    logic load;   // latch a new request and set up its bit sources
    logic step;   // work on the current request
  } abp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic done;   // all bits absorbed and the closing result issued
  } abp_stat_t;

  // Both CRCs advanced over one completed byte, returned as {crc16, crc8}
  function automatic logic [23:0] crc_byte(input logic [7:0] c8_in,
                                           input logic [15:0] c16_in,
                                           input logic [7:0] b);
    logic [7:0]  c8;
    logic [15:0] c16;
    c8  = c8_in ^ b;
    c16 = c16_in ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      c8  = c8[7]   ? ((c8 << 1) ^ CRC8_POLY)   : (c8 << 1);
      c16 = c16[15] ? ((c16 << 1) ^ CRC16_POLY) : (c16 << 1);
    end
    return {c16, c8};
  endfunction

  // UTF-8 style number, left-justified, returned as {bits, bit count}
  function automatic logic [70:0] utf8_bits(input logic [63:0] v);
    logic [2:0]  extra;
    logic [7:0]  lead;
    logic [55:0] acc;
    logic [63:0] bits;
    if (v < 64'h80) begin
      extra = 3'd0;
      lead  = v[7:0];
    end else if (v < 64'h800) begin
      extra = 3'd1;
      lead  = 8'hC0 | {2'b00, v[11:6]};
    end else if (v < 64'h10000) begin
      extra = 3'd2;
      lead  = 8'hE0 | {4'h0, v[15:12]};
    end else if (v < 64'h200000) begin
      extra = 3'd3;
      lead  = 8'hF0 | {5'h00, v[20:18]};
    end else if (v < 64'h4000000) begin
      extra = 3'd4;
      lead  = 8'hF8 | {6'h00, v[25:24]};
    end else if (v < 64'h80000000) begin
      extra = 3'd5;
      lead  = 8'hFC | {7'h00, v[30]};
    end else begin
      extra = 3'd6;
      lead  = 8'hFE;
    end
    acc = {48'h0, lead};
    for (int i = 5; i >= 0; i--) begin
      if (3'(i) < extra) acc = (acc << 8) | {48'h0, 2'b10, v[6*i +: 6]};
    end
    bits = {acc, 8'h00} << (6'd8 * (6'd6 - {3'd0, extra}));
    return {bits, 1'b0, extra + 3'd1, 3'd0};
  endfunction

endpackage

### src/abp_ctrl.sv
module abp_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              req_valid,
  output logic              req_ready,
  output abp_pkg::abp_cmd_t cmd,
  input  abp_pkg::abp_stat_t stat
);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_RUN  = 2'b10
  } state_t;

  state_t state_r, state_nxt;

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:  if (req_valid) state_nxt = S_RUN;
      S_RUN:   if (stat.done) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else        state_r <= state_nxt;
  end

  assign req_ready = (state_r == S_IDLE);
  assign cmd.load  = (state_r == S_IDLE) && req_valid;
  assign cmd.step  = (state_r == S_RUN);

endmodule

### src/abp_datapath.sv
module abp_datapath #(
  parameter int MAX_QUOTIENT = 255
) (
  input  logic               clk,
  input  logic               rst_n,
  input  abp_pkg::abp_cmd_t  cmd,
  output abp_pkg::abp_stat_t stat,
  input  logic [2:0]         action,
  input  logic [63:0]        value,
  input  logic [6:0]         bit_count,
  input  logic signed [31:0] sample,
  input  logic [4:0]         rice_param,
  output logic               res_valid,
  input  logic               res_ready,
  output logic [7:0]         res_byte,
  output logic               res_byte_valid,
  output logic [7:0]         res_crc8,
  output logic [15:0]        res_crc16,
  output logic [2:0]         res_pending,
  output logic [31:0]        res_total,
  output logic               res_qerr,
  output logic               res_last
);

  // Packer state
  logic [7:0]  partial_r;
  logic [2:0]  pc_r;
  logic [7:0]  crc8_r;
  logic [15:0] crc16_r;
  logic [31:0] total_r;
  // Bit sources of the current request: a zero run, then left-justified bits
  logic [7:0]  zcnt_r;
  logic [63:0] src_r;
  logic [6:0]  scnt_r;
  logic        emitted_r;
  logic        qerr_r;

  // Request setup
  logic [31:0] zz;
  logic [31:0] quo;
  logic [31:0] rem_bits;
  logic [6:0]  raw_cnt;
  logic [70:0] utf8;
  always_comb begin
    zz       = {sample[30:0], 1'b0} ^ {32{sample[31]}};
    quo      = zz >> rice_param;
    rem_bits = (32'd1 << rice_param) | (zz & ((32'd1 << rice_param) - 32'd1));
    raw_cnt  = (bit_count > 7'd64) ? 7'd64 : bit_count;
    utf8     = abp_pkg::utf8_bits(value);
  end

  // One step: fill the partial byte from the current source
  logic        from_z;
  logic [7:0]  avail;
  logic [3:0]  room;
  logic [3:0]  n;
  logic [7:0]  top;
  logic [15:0] merged;
  logic [3:0]  ncnt;
  logic        full;
  logic [7:0]  zcnt_nxt;
  logic [6:0]  scnt_nxt;
  logic [63:0] src_nxt;
  logic [8:0]  rem;
  logic [8:0]  rem_nxt;
  logic [23:0] crc_nxt;
  logic [31:0] total_inc;
  logic        ok;
  logic        issue;
  always_comb begin
    from_z    = (zcnt_r != 8'd0);
    avail     = from_z ? zcnt_r : {1'b0, scnt_r};
    room      = 4'd8 - {1'b0, pc_r};
    n         = (avail < {4'd0, room}) ? avail[3:0] : room;
    top       = from_z ? 8'h00 : src_r[63:56];
    merged    = ({8'h00, partial_r} << n) | {8'h00, top >> (4'd8 - n)};
    ncnt      = {1'b0, pc_r} + n;
    full      = ncnt[3];
    zcnt_nxt  = from_z ? zcnt_r - {4'd0, n} : zcnt_r;
    scnt_nxt  = from_z ? scnt_r : scnt_r - {3'd0, n};
    src_nxt   = from_z ? src_r : src_r << n;
    rem       = {1'b0, zcnt_r} + {2'b00, scnt_r};
    rem_nxt   = {1'b0, zcnt_nxt} + {2'b00, scnt_nxt};
    crc_nxt   = abp_pkg::crc_byte(crc8_r, crc16_r, merged[7:0]);
    total_inc = (total_r == 32'hFFFF_FFFF) ? total_r : total_r + 32'd1;
    ok        = !res_valid || res_ready;
    issue     = cmd.step && ok && ((rem != 9'd0) ? full : !emitted_r);
  end

  assign stat.done = cmd.step && ok && (rem == 9'd0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      partial_r <= 8'h00;
      pc_r      <= 3'd0;
      crc8_r    <= 8'h00;
      crc16_r   <= 16'h0000;
      total_r   <= 32'd0;
      zcnt_r    <= 8'd0;
      scnt_r    <= 7'd0;
      emitted_r <= 1'b0;
      qerr_r    <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      // output register occupancy
      if (issue) res_valid <= 1'b1;
      else if (res_ready) res_valid <= 1'b0;
      if (cmd.load) begin
        emitted_r <= 1'b0;
        case (action)
          abp_pkg::ACT_RAW: begin
            qerr_r <= 1'b0;
            zcnt_r <= 8'd0;
            src_r  <= value << (7'd64 - raw_cnt);
            scnt_r <= raw_cnt;
          end
          abp_pkg::ACT_RICE: begin
            if (quo > 32'(MAX_QUOTIENT)) begin
              qerr_r <= 1'b1;
              zcnt_r <= 8'd0;
              scnt_r <= 7'd0;
            end else begin
              qerr_r <= 1'b0;
              zcnt_r <= quo[7:0];
              src_r  <= {32'h0, rem_bits} << (6'd63 - {1'b0, rice_param});
              scnt_r <= {2'b00, rice_param} + 7'd1;
            end
          end
          abp_pkg::ACT_UTF8: begin
            qerr_r <= 1'b0;
            zcnt_r <= 8'd0;
            src_r  <= utf8[70:7];
            scnt_r <= utf8[6:0];
          end
          abp_pkg::ACT_ALIGN: begin
            qerr_r <= 1'b0;
            zcnt_r <= (pc_r != 3'd0) ? {4'd0, room} : 8'd0;
            scnt_r <= 7'd0;
          end
          abp_pkg::ACT_CLEAR: begin
            qerr_r    <= 1'b0;
            zcnt_r    <= 8'd0;
            scnt_r    <= 7'd0;
            partial_r <= 8'h00;
            pc_r      <= 3'd0;
            crc8_r    <= 8'h00;
            crc16_r   <= 16'h0000;
            total_r   <= 32'd0;
          end
          abp_pkg::ACT_RESTART: begin
            qerr_r  <= 1'b0;
            zcnt_r  <= 8'd0;
            scnt_r  <= 7'd0;
            crc8_r  <= 8'h00;
            crc16_r <= 16'h0000;
          end
          default: begin
            qerr_r <= 1'b0;
            zcnt_r <= 8'd0;
            scnt_r <= 7'd0;
          end
        endcase
      end else if (cmd.step && ok) begin
        if (rem != 9'd0) begin
          zcnt_r <= zcnt_nxt;
          scnt_r <= scnt_nxt;
          src_r  <= src_nxt;
          if (full) begin
            partial_r      <= 8'h00;
            pc_r           <= 3'd0;
            crc8_r         <= crc_nxt[7:0];
            crc16_r        <= crc_nxt[23:8];
            total_r        <= total_inc;
            emitted_r      <= 1'b1;
            res_byte       <= merged[7:0];
            res_byte_valid <= 1'b1;
            res_crc8       <= crc_nxt[7:0];
            res_crc16      <= crc_nxt[23:8];
            res_pending    <= 3'd0;
            res_total      <= total_inc;
            res_qerr       <= 1'b0;
            res_last       <= (rem_nxt < 9'd8);
          end else begin
            partial_r <= merged[7:0];
            pc_r      <= ncnt[2:0];
          end
        end else if (!emitted_r) begin
          // request that completed no byte
          res_byte       <= 8'h00;
          res_byte_valid <= 1'b0;
          res_crc8       <= crc8_r;
          res_crc16      <= crc16_r;
          res_pending    <= pc_r;
          res_total      <= total_r;
          res_qerr       <= qerr_r;
          res_last       <= 1'b1;
        end
      end
    end
  end

`ifndef SYNTH
  // a completed byte always leaves the partial byte empty
  a_byte_pending: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid && res_byte_valid |-> res_pending == 3'd0)
    else $error("byte result with pending bits");
  // a result without a byte carries a zero byte and closes its request
  a_nobyte_last: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid && !res_byte_valid |-> res_byte == 8'h00 && res_last)
    else $error("empty result malformed");
  // a quotient error never comes with a byte
  a_qerr: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid && res_qerr |-> !res_byte_valid)
    else $error("quotient error with byte");
  // done is only reported once every source bit is absorbed
  a_done: assert property (@(posedge clk) disable iff (!rst_n)
    stat.done |-> zcnt_r == 8'd0 && scnt_r == 7'd0)
    else $error("done with bits left");
`endif

endmodule

### src/audio_bitstream_packer.sv
// MSB-first bitstream packer with running CRC-8 and CRC-16.
// Input channel: one request per accepted beat; in_tuser is the action
// (raw bits, Rice sample, UTF-8 number, align, clear, CRC restart), in_tdata
// carries the operands. A request is taken only when the previous one has
// issued all of its results.
// Output channel: one result per completed byte, or one result without a
// byte when a request completes none; out_tlast marks a request's final one.
// A request is first set up, then worked on in steps that each fill the
// partial byte with at most 8 bits from the zero run or the bit register,
// then closed by a final step. Each step goes through the partial-byte
// merge and the CRC byte update.
// A result waits in the output register; while the receiver stalls, the
// packer holds and no further byte is formed. Synchronous reset clears the
// partial byte, both CRCs and the byte count and empties the output register.
module audio_bitstream_packer #(
  parameter int MAX_QUOTIENT = 255
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [111:0] in_tdata,   // value[63:0], bit_count[70:64], sample[102:71],
                                   // rice_param[107:103], zero fill
  input  logic [2:0]   in_tuser,   // action
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [71:0]  out_tdata,  // out_byte[7:0], crc8_after[15:8],
                                   // crc16_after[31:16], pending_bits[34:32],
                                   // byte_total[66:35], zero fill
  output logic [1:0]   out_tuser,  // byte_valid[0], quotient_error[1]
  output logic         out_tlast
);

  abp_pkg::abp_cmd_t  cmd;
  abp_pkg::abp_stat_t stat;

  logic [7:0]  r_byte;
  logic        r_bv;
  logic [7:0]  r_c8;
  logic [15:0] r_c16;
  logic [2:0]  r_pend;
  logic [31:0] r_tot;
  logic        r_qe;

  abp_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (in_tvalid),
    .req_ready (in_tready),
    .cmd       (cmd),
    .stat      (stat)
  );

  abp_datapath #(.MAX_QUOTIENT(MAX_QUOTIENT)) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .stat           (stat),
    .action         (in_tuser),
    .value          (in_tdata[63:0]),
    .bit_count      (in_tdata[70:64]),
    .sample         (in_tdata[102:71]),
    .rice_param     (in_tdata[107:103]),
    .res_valid      (out_tvalid),
    .res_ready      (out_tready),
    .res_byte       (r_byte),
    .res_byte_valid (r_bv),
    .res_crc8       (r_c8),
    .res_crc16      (r_c16),
    .res_pending    (r_pend),
    .res_total      (r_tot),
    .res_qerr       (r_qe),
    .res_last       (out_tlast)
  );

  assign out_tdata = {5'd0, r_tot, r_pend, r_c16, r_c8, r_byte};
  assign out_tuser = {r_qe, r_bv};

endmodule

### verif/testbench.sv
`timescale 1ns / 1ps

module testbench;

  localparam int          QUOTIENT_LIMIT = 255;
  localparam int          MAX_PER_REQ    = 36;
  localparam int          WATCHDOG_LIMIT = 5000;
  localparam logic [2:0]  ACT_SPARE6     = 3'd6;
  localparam logic [2:0]  ACT_SPARE7     = 3'd7;

  // One expected output beat
  typedef struct {
    logic [7:0]  data_byte;
    logic        byte_valid;
    logic [7:0]  crc8;
    logic [15:0] crc16;
    logic [2:0]  pending;
    logic [31:0] total;
    logic        qerr;
    logic        last;
  } packed_byte_t;

  logic         clk;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  logic [111:0] in_tdata;
  logic [2:0]   in_tuser;
  logic         out_tvalid;
  logic         out_tready;
  logic [71:0]  out_tdata;
  logic [1:0]   out_tuser;
  logic         out_tlast;

  audio_bitstream_packer DUT (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser), .out_tlast(out_tlast)
  );

  // Shadow packer state
  logic [7:0]  shadow_partial;
  logic [2:0]  shadow_count;
  logic [7:0]  shadow_crc8;
  logic [15:0] shadow_crc16;
  logic [31:0] shadow_total;
  int          beats_this_req;

  packed_byte_t expected_bytes[$];
  int  error_count   = 0;
  int  requests_sent;
  int  bytes_checked = 0;
  int  qerr_seen     = 0;
  int  idle_cycles;
  int  send_idle_pct;
  int  recv_stall_pct;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Record a result beat from the current shadow state
  function automatic void record_beat(logic [7:0] b, logic valid, logic qerr);
    packed_byte_t r;
    r.data_byte  = valid ? b : 8'h00;
    r.byte_valid = valid;
    r.crc8       = shadow_crc8;
    r.crc16      = shadow_crc16;
    r.pending    = shadow_count;
    r.total      = shadow_total;
    r.qerr       = qerr;
    r.last       = 1'b0;
    expected_bytes.insert(expected_bytes.size(), r);
    beats_this_req++;
  endfunction

  function automatic void complete_byte(logic [7:0] b);
    logic [7:0]  c8;
    logic [15:0] c16;
    c8  = shadow_crc8 ^ b;
    c16 = shadow_crc16 ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      c8  = c8[7]   ? ((c8 << 1) ^ 8'h07)      : (c8 << 1);
      c16 = c16[15] ? ((c16 << 1) ^ 16'h8005)  : (c16 << 1);
    end
    shadow_crc8  = c8;
    shadow_crc16 = c16;
    if (shadow_total != 32'hFFFF_FFFF) shadow_total++;
    if (beats_this_req < MAX_PER_REQ) record_beat(b, 1'b1, 1'b0);
  endfunction

  function automatic void shift_in_bit(logic bv);
    logic [7:0] b;
    shadow_partial = {shadow_partial[6:0], bv};
    shadow_count++;
    if (shadow_count == 3'd0) begin
      b = shadow_partial;
      shadow_partial = 8'h00;
      complete_byte(b);
    end
  endfunction

  function automatic void shift_in_bits(logic [63:0] v, int n);
    for (int i = n - 1; i >= 0; i--) shift_in_bit(v[i]);
  endfunction

  function automatic void encode_number(logic [63:0] v);
    int         extra;
    logic [63:0] lead;
    if (v < 64'h80) begin
      shift_in_bits(v, 8);
      return;
    end
    if (v < 64'h800)           begin extra = 1; lead = 64'hC0; end
    else if (v < 64'h10000)    begin extra = 2; lead = 64'hE0; end
    else if (v < 64'h200000)   begin extra = 3; lead = 64'hF0; end
    else if (v < 64'h4000000)  begin extra = 4; lead = 64'hF8; end
    else if (v < 64'h80000000) begin extra = 5; lead = 64'hFC; end
    else                       begin extra = 6; lead = 64'hFE; end
    if (extra < 6) shift_in_bits(lead | (v >> (6 * extra)), 8);
    else shift_in_bits(lead, 8);
    for (int i = extra; i > 0; i--)
      shift_in_bits(64'h80 | ((v >> (6 * (i - 1))) & 64'h3F), 8);
  endfunction

  function automatic void clear_shadow();
    shadow_partial = 8'h00;
    shadow_count   = 3'd0;
    shadow_crc8    = 8'h00;
    shadow_crc16   = 16'h0000;
    shadow_total   = 32'h0;
  endfunction

  // Expected beats for one request, appended to expected_bytes
  function automatic void predict_request(logic [2:0] act, logic [63:0] value,
                                          logic [6:0] cnt, logic [31:0] sample,
                                          logic [4:0] k);
    logic [31:0]  zig;
    logic [31:0]  quot;
    int           n;
    packed_byte_t r;
    beats_this_req = 0;
    case (act)
      abp_pkg::ACT_RAW: begin
        n = (cnt > 64) ? 64 : cnt;
        shift_in_bits(value, n);
      end
      abp_pkg::ACT_RICE: begin
        zig  = {sample[30:0], 1'b0} ^ {32{sample[31]}};
        quot = zig >> k;
        if (quot > QUOTIENT_LIMIT) begin
          record_beat(8'h00, 1'b0, 1'b1);
        end else begin
          for (int i = 0; i < quot; i++) shift_in_bit(1'b0);
          shift_in_bit(1'b1);
          if (k > 0) shift_in_bits({32'h0, zig}, k);
        end
      end
      abp_pkg::ACT_UTF8:    encode_number(value);
      abp_pkg::ACT_ALIGN:   if (shadow_count != 0) shift_in_bits(64'h0, 8 - shadow_count);
      abp_pkg::ACT_CLEAR:   clear_shadow();
      abp_pkg::ACT_RESTART: begin
        shadow_crc8  = 8'h00;
        shadow_crc16 = 16'h0000;
      end
      default: ;
    endcase
    if (beats_this_req == 0) record_beat(8'h00, 1'b0, 1'b0);
    r = expected_bytes[expected_bytes.size() - 1];
    r.last = 1'b1;
    expected_bytes[expected_bytes.size() - 1] = r;
  endfunction

  // Send one request; prediction is queued before the beat goes out
  task automatic send_request(logic [2:0] act, logic [63:0] value, logic [6:0] cnt,
                              logic [31:0] sample, logic [4:0] k);
    predict_request(act, value, cnt, sample, k);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= act;
    in_tdata  <= {4'h0, k, sample, cnt, value};
    @(posedge clk iff in_tready);
    requests_sent++;
  endtask

  task automatic end_burst();
    in_tvalid <= 1'b0;
    @(posedge clk);
  endtask

  // Receiver backpressure
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Result checker
  always @(posedge clk) begin
    packed_byte_t e;
    if (rst_n && out_tvalid && out_tready) begin
      bytes_checked++;
      if (expected_bytes.size() == 0) begin
        $error("unexpected result: tdata=%h tuser=%b", out_tdata, out_tuser);
        error_count++;
      end else begin
        e = expected_bytes.pop_front();
        if (out_tuser[1]) qerr_seen++;
        if (out_tdata[7:0] !== e.data_byte) begin
          $error("out_byte: expected %h actual %h", e.data_byte, out_tdata[7:0]);
          error_count++;
        end
        if (out_tuser[0] !== e.byte_valid) begin
          $error("byte_valid: expected %b actual %b", e.byte_valid, out_tuser[0]);
          error_count++;
        end
        if (out_tdata[15:8] !== e.crc8) begin
          $error("crc8_after: expected %h actual %h", e.crc8, out_tdata[15:8]);
          error_count++;
        end
        if (out_tdata[31:16] !== e.crc16) begin
          $error("crc16_after: expected %h actual %h", e.crc16, out_tdata[31:16]);
          error_count++;
        end
        if (out_tdata[34:32] !== e.pending) begin
          $error("pending_bits: expected %0d actual %0d", e.pending, out_tdata[34:32]);
          error_count++;
        end
        if (out_tdata[66:35] !== e.total) begin
          $error("byte_total: expected %0d actual %0d", e.total, out_tdata[66:35]);
          error_count++;
        end
        if (out_tuser[1] !== e.qerr) begin
          $error("quotient_error: expected %b actual %b", e.qerr, out_tuser[1]);
          error_count++;
        end
        if (out_tlast !== e.last) begin
          $error("last: expected %b actual %b", e.last, out_tlast);
          error_count++;
        end
      end
    end
  end

  // Watchdog on cycles with no transfer on either channel
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog expired, %0d results outstanding", expected_bytes.size());
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  task automatic test_raw_bits();
    send_request(abp_pkg::ACT_RAW, 64'hFFFF_FFFF_FFFF_FFFF, 7'd1, 32'h0, 5'd0);
    send_request(abp_pkg::ACT_RAW, 64'hFFFF_FFFF_FFFF_FFFF, 7'd64, 32'h0, 5'd0);
    send_request(abp_pkg::ACT_RAW, 64'hA5A5_5A5A_0F0F_F0F0, 7'd0, 32'h0, 5'd0);
    send_request(abp_pkg::ACT_RAW, 64'h0123_4567_89AB_CDEF, 7'd127, 32'h0, 5'd0);
    send_request(abp_pkg::ACT_RAW, 64'h0, 7'd64, 32'h0, 5'd0);
    send_request(abp_pkg::ACT_RAW, 64'h5, 7'd3, 32'h0, 5'd0);
  endtask

  task automatic test_rice();
    send_request(abp_pkg::ACT_RICE, 64'h0, 7'd0, 32'h0, 5'd0);
    send_request(abp_pkg::ACT_RICE, 64'h0, 7'd0, 32'hFFFF_FFFF, 5'd0);
    send_request(abp_pkg::ACT_RICE, 64'h0, 7'd0, 32'hFFFF_FF80, 5'd0);  // quotient at limit
    send_request(abp_pkg::ACT_RICE, 64'h0, 7'd0, 32'd128, 5'd0);        // just over the limit
    send_request(abp_pkg::ACT_RICE, 64'h0, 7'd0, 32'h8000_0000, 5'd31); // widest remainder
    send_request(abp_pkg::ACT_RICE, 64'h0, 7'd0, 32'h7FFF_FFFF, 5'd30);
    send_request(abp_pkg::ACT_RICE, 64'h0, 7'd0, 32'h8000_0000, 5'd0);
    send_request(abp_pkg::ACT_RICE, 64'h0, 7'd0, 32'd4000, 5'd4);
  endtask

  task automatic test_utf8();
    send_request(abp_pkg::ACT_UTF8, 64'h7F, 7'd0, 32'h0, 5'd0);
    send_request(abp_pkg::ACT_UTF8, 64'h7FF, 7'd0, 32'h0, 5'd0);
    send_request(abp_pkg::ACT_UTF8, 64'hFFFF, 7'd0, 32'h0, 5'd0);
    send_request(abp_pkg::ACT_UTF8, 64'h1F_FFFF, 7'd0, 32'h0, 5'd0);
    send_request(abp_pkg::ACT_UTF8, 64'h3FF_FFFF, 7'd0, 32'h0, 5'd0);
    send_request(abp_pkg::ACT_UTF8, 64'h7FFF_FFFF, 7'd0, 32'h0, 5'd0);
    send_request(abp_pkg::ACT_UTF8, 64'hF_FFFF_FFFF, 7'd0, 32'h0, 5'd0);
    // upper bits dropped
    send_request(abp_pkg::ACT_UTF8, 64'hFFFF_FFFF_FFFF_FFFF, 7'd0, 32'h0, 5'd0);
  endtask

  task automatic test_control();
    send_request(abp_pkg::ACT_RAW, 64'h1, 7'd5, 32'h0, 5'd0);
    send_request(abp_pkg::ACT_RESTART, 64'h0, 7'd0, 32'h0, 5'd0);  // partial byte survives
    send_request(abp_pkg::ACT_ALIGN, 64'h0, 7'd0, 32'h0, 5'd0);
    send_request(abp_pkg::ACT_ALIGN, 64'h0, 7'd0, 32'h0, 5'd0);    // already aligned
    send_request(ACT_SPARE6, 64'hFFFF_FFFF_FFFF_FFFF, 7'd64, 32'hFFFF_FFFF, 5'd31);
    send_request(ACT_SPARE7, 64'h0, 7'd0, 32'h0, 5'd0);
    send_request(abp_pkg::ACT_RAW, 64'h3, 7'd2, 32'h0, 5'd0);
    send_request(abp_pkg::ACT_CLEAR, 64'h0, 7'd0, 32'h0, 5'd0);
  endtask

  task automatic test_random(int count);
    logic [2:0]  act;
    logic [63:0] value;
    logic [31:0] sample;
    logic [4:0]  k;
    int          sel;
    int          mag;
    for (int n = 0; n < count; n++) begin
      sel    = $urandom_range(99);
      value  = {$urandom, $urandom};
      k      = 5'($urandom_range(31));
      sample = $urandom;
      if (sel < 30) begin
        act = abp_pkg::ACT_RAW;
      end else if (sel < 65) begin
        act = abp_pkg::ACT_RICE;
        // mostly residuals that keep the quotient in range
        if ($urandom_range(9) != 0) begin
          mag    = (k + $urandom_range(8) > 30) ? 30 : k + $urandom_range(8);
          sample = $urandom & ((32'h1 << mag) - 1);
          if ($urandom_range(1)) sample = -sample;
        end
      end else if (sel < 82) begin
        act = abp_pkg::ACT_UTF8;
        value = value >> $urandom_range(63);
      end else if (sel < 92) begin
        act = abp_pkg::ACT_ALIGN;
      end else if (sel < 95) begin
        act = abp_pkg::ACT_CLEAR;
      end else if (sel < 98) begin
        act = abp_pkg::ACT_RESTART;
      end else begin
        act = $urandom_range(1) ? ACT_SPARE6 : ACT_SPARE7;
      end
      send_request(act, value, 7'($urandom_range(127)), sample, k);
    end
  endtask

  task automatic drain();
    while (expected_bytes.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  initial begin
    rst_n          = 1'b0;
    in_tvalid      = 1'b0;
    in_tdata       = '0;
    in_tuser       = abp_pkg::ACT_RAW;
    requests_sent  = 0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    clear_shadow();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_raw_bits();
    test_rice();
    test_utf8();
    test_control();
    end_burst();

    send_idle_pct = 0;  recv_stall_pct = 0;
    test_random(110);
    send_idle_pct = 63; recv_stall_pct = 0;
    test_random(110);
    send_idle_pct = 0;  recv_stall_pct = 63;
    test_random(110);
    send_idle_pct = 25; recv_stall_pct = 25;
    test_random(120);
    end_burst();
    drain();

    $display("Covered %0d requests (raw, Rice, UTF-8, align, clear, CRC restart, spare codes)",
             requests_sent);
    $display("and checked %0d result beats, %0d with quotient errors, under four idle mixes",
             bytes_checked, qerr_seen);
    if (error_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
